@@ design/mard_pkg.sv @@
package mard_pkg;

    // Field widths of the transfer payloads
    localparam int CMD_W     = 2;
    localparam int ADDR_W    = 64;
    localparam int LENGTH_W  = 32;
    localparam int MODE_W    = 2;
    localparam int COMP_W    = 4;
    localparam int STATUS_W  = 3;

    // Defaults for the top-level parameters
    localparam int RANGE_ENTRIES_DEF   = 16;
    localparam int RANGE_SIZE_BITS_DEF = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DENIED  = 3'd4;

    // Permission bits of a range
    localparam int PERM_READ_BIT  = 0;
    localparam int PERM_WRITE_BIT = 1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COMP_W-1:0]   target;
        logic [LENGTH_W-1:0] offset;
    } result_t;

endpackage

@@ design/mmio_address_range_decoder.sv @@
// Memory-mapped I/O range decoder. Register items (cmd 0) add a range of
// base, size, permissions and component to a table of RANGE_ENTRIES
// entries and answer ok, overlap or full; read and write lookups (cmd 1, 2)
// answer hit with component and offset, miss, or permission denied, and
// other codes answer miss. The block takes one item per cycle while the
// output side is not stalled: the item is held in an input register,
// checked against all entries at once by one layer of per-entry
// subtract-and-compare logic, and the answer lands in the result
// register. A registered range is visible to the very next item. Range
// sizes keep the low RANGE_SIZE_BITS bits of length, at most 32.
module mmio_address_range_decoder #(
    parameter int RANGE_ENTRIES   = mard_pkg::RANGE_ENTRIES_DEF,
    parameter int RANGE_SIZE_BITS = mard_pkg::RANGE_SIZE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [mard_pkg::CMD_W-1:0]      cmd,
    input  logic [mard_pkg::ADDR_W-1:0]     address,
    input  logic [mard_pkg::LENGTH_W-1:0]   length,
    input  logic [mard_pkg::MODE_W-1:0]     access_mode,
    input  logic [mard_pkg::COMP_W-1:0]     component_number,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mard_pkg::STATUS_W-1:0]   status,
    output logic [mard_pkg::COMP_W-1:0]     target_component,
    output logic [mard_pkg::LENGTH_W-1:0]   range_offset
);
    import mard_pkg::*;

    localparam int SIZE_W = (RANGE_SIZE_BITS < LENGTH_W) ? RANGE_SIZE_BITS : LENGTH_W;
    localparam int IDX_W  = $clog2(RANGE_ENTRIES);

    logic                s_valid_reg;
    logic [CMD_W-1:0]    s_cmd_reg;
    logic [ADDR_W-1:0]   s_address_reg;
    logic [LENGTH_W-1:0] s_length_reg;
    logic [MODE_W-1:0]   s_mode_reg;
    logic [COMP_W-1:0]   s_comp_reg;
    logic                out_valid_reg;
    result_t             result_reg;
    result_t             result_next;
    logic                advance;
    logic                match_we;
    logic                tbl_we;
    logic [IDX_W-1:0]    tbl_idx;
    logic [RANGE_ENTRIES-1:0] entry_valid;
    logic [ADDR_W-1:0]   entry_base   [RANGE_ENTRIES];
    logic [SIZE_W-1:0]   entry_size   [RANGE_ENTRIES];
    logic [MODE_W-1:0]   entry_perm   [RANGE_ENTRIES];
    logic [COMP_W-1:0]   entry_target [RANGE_ENTRIES];

    // Move the held item on when the result register is free or drains
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s_valid_reg || advance;
    assign tbl_we   = s_valid_reg && advance && match_we;

    // Hold the accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s_cmd_reg     <= cmd;
            s_address_reg <= address;
            s_length_reg  <= length;
            s_mode_reg    <= access_mode;
            s_comp_reg    <= component_number;
        end
    end

    mard_table #(
        .Entries (RANGE_ENTRIES),
        .SizeW   (SIZE_W),
        .IdxW    (IDX_W)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (tbl_we),
        .wr_idx       (tbl_idx),
        .wr_base      (s_address_reg),
        .wr_size      (s_length_reg[SIZE_W-1:0]),
        .wr_perm      (s_mode_reg),
        .wr_target    (s_comp_reg),
        .entry_valid  (entry_valid),
        .entry_base   (entry_base),
        .entry_size   (entry_size),
        .entry_perm   (entry_perm),
        .entry_target (entry_target)
    );

    mard_match #(
        .Entries (RANGE_ENTRIES),
        .SizeW   (SIZE_W),
        .IdxW    (IDX_W)
    ) u_match (
        .cmd          (s_cmd_reg),
        .address      (s_address_reg),
        .length       (s_length_reg),
        .entry_valid  (entry_valid),
        .entry_base   (entry_base),
        .entry_size   (entry_size),
        .entry_perm   (entry_perm),
        .entry_target (entry_target),
        .result       (result_next),
        .wr_en        (match_we),
        .wr_idx       (tbl_idx)
    );

    // Load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = result_reg.status;
    assign target_component = result_reg.target;
    assign range_offset     = result_reg.offset;

`ifndef SYNTHESIS
    // A stored range is always answered with an ok result
    a_write_gives_ok: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |=> out_valid_reg && (result_reg.status == ST_OK))
        else $error("table written without an ok result");

    // Entries are never freed
    a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(entry_valid) >= $past($countones(entry_valid))))
        else $error("table entry lost");

    // Anything but a hit carries no component and no offset
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (result_reg.status != ST_OK)
            |-> (result_reg.target == '0) && (result_reg.offset == '0))
        else $error("nonzero fields on a failed result");

    // A stalled item stays in the input register
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg && !advance |=> s_valid_reg && $stable(s_address_reg))
        else $error("held item dropped");
`endif

endmodule

@@ design/mard_table.sv @@
module mard_table #(
    parameter int Entries = 16,
    parameter int SizeW   = 32,
    parameter int IdxW    = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [IdxW-1:0]                 wr_idx,
    input  logic [mard_pkg::ADDR_W-1:0]     wr_base,
    input  logic [SizeW-1:0]                wr_size,
    input  logic [mard_pkg::MODE_W-1:0]     wr_perm,
    input  logic [mard_pkg::COMP_W-1:0]     wr_target,
    output logic [Entries-1:0]              entry_valid,
    output logic [mard_pkg::ADDR_W-1:0]     entry_base [Entries],
    output logic [SizeW-1:0]                entry_size [Entries],
    output logic [mard_pkg::MODE_W-1:0]     entry_perm [Entries],
    output logic [mard_pkg::COMP_W-1:0]     entry_target [Entries]
);
    import mard_pkg::*;

    logic [Entries-1:0] valid_reg;
    logic [ADDR_W-1:0]  base_reg   [Entries];
    logic [SizeW-1:0]   size_reg   [Entries];
    logic [MODE_W-1:0]  perm_reg   [Entries];
    logic [COMP_W-1:0]  target_reg [Entries];

    // Mark an entry as taken once a range lands in it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // Store the range fields; read only while the entry is valid
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            base_reg[wr_idx]   <= wr_base;
            size_reg[wr_idx]   <= wr_size;
            perm_reg[wr_idx]   <= wr_perm;
            target_reg[wr_idx] <= wr_target;
        end
    end

    assign entry_valid  = valid_reg;
    assign entry_base   = base_reg;
    assign entry_size   = size_reg;
    assign entry_perm   = perm_reg;
    assign entry_target = target_reg;

endmodule

@@ design/mard_match.sv @@
module mard_match #(
    parameter int Entries = 16,
    parameter int SizeW   = 32,
    parameter int IdxW    = 4
) (
    input  logic [mard_pkg::CMD_W-1:0]      cmd,
    input  logic [mard_pkg::ADDR_W-1:0]     address,
    input  logic [mard_pkg::LENGTH_W-1:0]   length,
    input  logic [Entries-1:0]              entry_valid,
    input  logic [mard_pkg::ADDR_W-1:0]     entry_base [Entries],
    input  logic [SizeW-1:0]                entry_size [Entries],
    input  logic [mard_pkg::MODE_W-1:0]     entry_perm [Entries],
    input  logic [mard_pkg::COMP_W-1:0]     entry_target [Entries],
    output mard_pkg::result_t               result,
    output logic                            wr_en,
    output logic [IdxW-1:0]                 wr_idx
);
    import mard_pkg::*;

    logic [ADDR_W:0]    up_diff [Entries];  // address - base, top bit is borrow
    logic [ADDR_W:0]    dn_diff [Entries];  // base - address, top bit is borrow
    logic [LENGTH_W:0]  room    [Entries];  // size - length, top bit is borrow
    logic [LENGTH_W-1:0] size_ext [Entries];
    logic [LENGTH_W-1:0] len_masked;
    logic [Entries-1:0] hit;
    logic [Entries-1:0] exact;
    logic [Entries-1:0] meet;
    logic [Entries-1:0] sel;
    logic               free_any;
    logic [IdxW-1:0]    free_idx;
    logic [COMP_W-1:0]  sel_target;
    logic [MODE_W-1:0]  sel_perm;
    logic [LENGTH_W-1:0] sel_offset;
    logic               perm_ok;

    // Range length as stored in the table
    assign len_masked = LENGTH_W'(length[SizeW-1:0]);

    // Compare the item against every entry in parallel
    always_comb
    begin
        for (int i = 0; i < Entries; i++)
        begin
            size_ext[i] = LENGTH_W'(entry_size[i]);
            up_diff[i]  = {1'b0, address} - {1'b0, entry_base[i]};
            dn_diff[i]  = {1'b0, entry_base[i]} - {1'b0, address};
            room[i]     = {1'b0, size_ext[i]} - {1'b0, length};
            // Access lies wholly inside the entry
            hit[i]   = entry_valid[i] && !up_diff[i][ADDR_W] && !room[i][LENGTH_W]
                       && (up_diff[i][ADDR_W-1:0] <= ADDR_W'(room[i][LENGTH_W-1:0]));
            exact[i] = hit[i] && (up_diff[i][ADDR_W-1:0] == '0);
            // New range shares a byte with the entry
            if (!up_diff[i][ADDR_W])
            begin
                meet[i] = entry_valid[i]
                          && (up_diff[i][ADDR_W-1:0] < ADDR_W'(size_ext[i]));
            end
            else
            begin
                meet[i] = entry_valid[i]
                          && (dn_diff[i][ADDR_W-1:0] < ADDR_W'(len_masked));
            end
        end
    end

    // Two hits only for a zero-length access at the seam of adjacent
    // ranges; take the upper one, whose base equals the address
    assign sel = (|exact) ? exact : hit;

    // Gather the fields of the selected entry
    always_comb
    begin
        sel_target = '0;
        sel_perm   = '0;
        sel_offset = '0;
        for (int i = 0; i < Entries; i++)
        begin
            sel_target = sel_target | (entry_target[i] & {COMP_W{sel[i]}});
            sel_perm   = sel_perm | (entry_perm[i] & {MODE_W{sel[i]}});
            sel_offset = sel_offset | (up_diff[i][LENGTH_W-1:0] & {LENGTH_W{sel[i]}});
        end
    end

    // Find the lowest free entry
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = Entries - 1; i >= 0; i--)
        begin
            if (!entry_valid[i])
            begin
                free_any = 1'b1;
                free_idx = IdxW'(i);
            end
        end
    end

    assign perm_ok = (cmd == CMD_READ) ? sel_perm[PERM_READ_BIT] : sel_perm[PERM_WRITE_BIT];
    assign wr_idx  = free_idx;

    // Form the result and the table write
    always_comb
    begin
        result = '{status: ST_MISS, target: '0, offset: '0};
        wr_en  = 1'b0;
        unique case (cmd)
            CMD_REGISTER:
            begin
                if ((len_masked == '0) || (|meet))
                begin
                    result.status = ST_OVERLAP;
                end
                else if (!free_any)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    result.status = ST_OK;
                    wr_en         = 1'b1;
                end
            end
            CMD_READ, CMD_WRITE:
            begin
                if (|sel)
                begin
                    if (perm_ok)
                    begin
                        result.status = ST_OK;
                        result.target = sel_target;
                        result.offset = sel_offset;
                    end
                    else
                    begin
                        result.status = ST_DENIED;
                    end
                end
            end
            default:
            begin
                result.status = ST_MISS;
            end
        endcase
    end

endmodule

@@ verif/tb_mmio_address_range_decoder.sv @@
`timescale 1ns / 1ps

module tb_mmio_address_range_decoder;

    import mard_pkg::*;

    localparam int        RANGE_ENTRIES   = RANGE_ENTRIES_DEF;
    localparam int        RANGE_SIZE_BITS = RANGE_SIZE_BITS_DEF;
    localparam int        RANDOM_ITEMS    = 1626;
    localparam int        DIRECTED_ROWS   = 24;
    localparam int        HOLDOFF_AT      = 500;
    localparam int        HOLDOFF_CYCLES  = 400;
    localparam int        DRAIN_AT        = 1100;
    localparam int        CYCLE_LIMIT     = 400000;

    // Unused command code and range permission codes
    localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RO    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WO    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RW    = 2'd3;

    localparam logic [ADDR_W-1:0]   ADDR_TOP  = '1;
    localparam logic [LENGTH_W-1:0] LEN_MAX   = '1;
    localparam logic [LENGTH_W-1:0] SIZE_MASK = (RANGE_SIZE_BITS >= LENGTH_W) ? '1
                                              : ((32'd1 << RANGE_SIZE_BITS) - 32'd1);
    localparam result_t             NO_ANSWER = '0;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [ADDR_W-1:0]   addr;
        logic [LENGTH_W-1:0] len;
        logic [MODE_W-1:0]   mode;
        logic [COMP_W-1:0]   comp;
        logic                typed;
        result_t             want;
    } stim_row_t;

    logic                  clk              = 1'b0;
    logic                  rst_n            = 1'b0;
    logic                  in_valid         = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      cmd              = '0;
    logic [ADDR_W-1:0]     address          = '0;
    logic [LENGTH_W-1:0]   length           = '0;
    logic [MODE_W-1:0]     access_mode      = '0;
    logic [COMP_W-1:0]     component_number = '0;
    logic                  out_valid;
    logic                  out_ready        = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [COMP_W-1:0]     target_component;
    logic [LENGTH_W-1:0]   range_offset;

    // Shadow copy of the range table
    logic                  tbl_valid [RANGE_ENTRIES];
    logic [ADDR_W-1:0]     tbl_base  [RANGE_ENTRIES];
    logic [LENGTH_W-1:0]   tbl_size  [RANGE_ENTRIES];
    logic [MODE_W-1:0]     tbl_perm  [RANGE_ENTRIES];
    logic [COMP_W-1:0]     tbl_comp  [RANGE_ENTRIES];
    int                    tbl_used = 0;

    result_t               decode_answers_q [$];
    int                    items_sent     = 0;
    int                    mismatch_count = 0;
    int                    cycle_count    = 0;
    bit                    holdoff_done   = 1'b0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_READ,     64'h0,                  32'd1,        MODE_NONE, 4'd0,  1'b1,
          '{ST_MISS, 4'd0, 32'd0}},
        '{CMD_UNUSED,   ADDR_TOP,               LEN_MAX,      MODE_RW,   4'd15, 1'b1,
          '{ST_MISS, 4'd0, 32'd0}},
        '{CMD_REGISTER, 64'h0,                  32'd0,        MODE_RW,   4'd2,  1'b1,
          '{ST_OVERLAP, 4'd0, 32'd0}},
        '{CMD_REGISTER, 64'h1000,               32'h100,      MODE_RW,   4'd5,  1'b1,
          '{ST_OK, 4'd0, 32'd0}},
        '{CMD_REGISTER, 64'h10ff,               32'd1,        MODE_RO,   4'd6,  1'b1,
          '{ST_OVERLAP, 4'd0, 32'd0}},
        '{CMD_READ,     64'h1000,               32'h100,      MODE_NONE, 4'd0,  1'b1,
          '{ST_OK, 4'd5, 32'd0}},
        '{CMD_WRITE,    64'h1100,               32'd0,        MODE_RW,   4'd0,  1'b0, NO_ANSWER},
        '{CMD_READ,     64'h1100,               32'd1,        MODE_NONE, 4'd0,  1'b0, NO_ANSWER},
        '{CMD_REGISTER, ADDR_TOP,               LEN_MAX,      MODE_RO,   4'd15, 1'b1,
          '{ST_OK, 4'd0, 32'd0}},
        '{CMD_WRITE,    ADDR_TOP,               32'd1,        MODE_NONE, 4'd0,  1'b1,
          '{ST_DENIED, 4'd0, 32'd0}},
        '{CMD_READ,     ADDR_TOP,               LEN_MAX,      MODE_NONE, 4'd0,  1'b0, NO_ANSWER},
        '{CMD_REGISTER, 64'h2000,               32'h10,       MODE_NONE, 4'd3,  1'b1,
          '{ST_OK, 4'd0, 32'd0}},
        '{CMD_READ,     64'h2000,               32'd1,        MODE_NONE, 4'd0,  1'b1,
          '{ST_DENIED, 4'd0, 32'd0}},
        '{CMD_WRITE,    64'h2008,               32'd8,        MODE_NONE, 4'd0,  1'b1,
          '{ST_DENIED, 4'd0, 32'd0}},
        '{CMD_REGISTER, 64'h3000,               32'h1000,     MODE_WO,   4'd9,  1'b1,
          '{ST_OK, 4'd0, 32'd0}},
        '{CMD_WRITE,    64'h3fff,               32'd1,        MODE_NONE, 4'd0,  1'b0, NO_ANSWER},
        '{CMD_READ,     64'h3000,               32'd1,        MODE_NONE, 4'd0,  1'b1,
          '{ST_DENIED, 4'd0, 32'd0}},
        '{CMD_READ,     64'h0,                  32'd0,        MODE_NONE, 4'd0,  1'b0, NO_ANSWER},
        '{CMD_REGISTER, 64'hffff_ffff_0000_0000, LEN_MAX,     MODE_RW,   4'd1,  1'b0, NO_ANSWER},
        '{CMD_READ,     64'hffff_ffff_ffff_fffe, 32'd1,       MODE_NONE, 4'd0,  1'b0, NO_ANSWER},
        '{CMD_REGISTER, 64'h0fff,               32'd1,        MODE_RW,   4'd0,  1'b0, NO_ANSWER},
        '{CMD_READ,     64'h0fff,               32'd2,        MODE_NONE, 4'd0,  1'b0, NO_ANSWER},
        '{CMD_REGISTER, 64'h0,                  LEN_MAX,      MODE_RW,   4'd7,  1'b0, NO_ANSWER},
        '{CMD_WRITE,    64'h1050,               32'hb0,       MODE_NONE, 4'd0,  1'b0, NO_ANSWER}
    };

    mmio_address_range_decoder #(
        .RANGE_ENTRIES   (RANGE_ENTRIES),
        .RANGE_SIZE_BITS (RANGE_SIZE_BITS)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .address          (address),
        .length           (length),
        .access_mode      (access_mode),
        .component_number (component_number),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .target_component (target_component),
        .range_offset     (range_offset)
    );

    always #5 clk = ~clk;

    // Predict the answer to one item and update the shadow table
    function automatic result_t predict_decode(
        input logic [CMD_W-1:0]    c,
        input logic [ADDR_W-1:0]   a,
        input logic [LENGTH_W-1:0] l,
        input logic [MODE_W-1:0]   m,
        input logic [COMP_W-1:0]   n
    );
        result_t             r;
        logic [LENGTH_W-1:0] sz;
        logic                clash;
        logic                granted;
        int                  free_slot;
        int                  best;
        int                  i;
        r = NO_ANSWER;
        r.status = ST_MISS;
        if (c == CMD_REGISTER)
        begin
            sz = l & SIZE_MASK;
            clash = (sz == '0);
            free_slot = -1;
            for (i = 0; i < RANGE_ENTRIES; i++)
            begin
                if (tbl_valid[i])
                begin
                    if (a >= tbl_base[i])
                    begin
                        if ((a - tbl_base[i]) < {32'b0, tbl_size[i]})
                            clash = 1'b1;
                    end
                    else if ((tbl_base[i] - a) < {32'b0, sz})
                    begin
                        clash = 1'b1;
                    end
                end
                else if (free_slot < 0)
                begin
                    free_slot = i;
                end
            end
            if (clash)
                r.status = ST_OVERLAP;
            else if (free_slot < 0)
                r.status = ST_FULL;
            else
            begin
                tbl_valid[free_slot] = 1'b1;
                tbl_base[free_slot]  = a;
                tbl_size[free_slot]  = sz;
                tbl_perm[free_slot]  = m;
                tbl_comp[free_slot]  = n;
                tbl_used++;
                r.status = ST_OK;
            end
        end
        else if (c == CMD_READ || c == CMD_WRITE)
        begin
            best = -1;
            for (i = 0; i < RANGE_ENTRIES; i++)
            begin
                if (tbl_valid[i] && tbl_base[i] <= a &&
                    (best < 0 || tbl_base[i] > tbl_base[best]))
                    best = i;
            end
            if (best >= 0 && tbl_size[best] >= l &&
                (a - tbl_base[best]) <= {32'b0, tbl_size[best] - l})
            begin
                granted = (c == CMD_READ) ? tbl_perm[best][PERM_READ_BIT]
                                          : tbl_perm[best][PERM_WRITE_BIT];
                if (granted)
                begin
                    r.status = ST_OK;
                    r.target = tbl_comp[best];
                    r.offset = LENGTH_W'(a - tbl_base[best]);
                end
                else
                begin
                    r.status = ST_DENIED;
                end
            end
        end
        return r;
    endfunction

    // Pace the sender in bursts, then hold the item until the transfer
    int burst_left = 0;

    task automatic offer_item(
        input logic [CMD_W-1:0]    c,
        input logic [ADDR_W-1:0]   a,
        input logic [LENGTH_W-1:0] l,
        input logic [MODE_W-1:0]   m,
        input logic [COMP_W-1:0]   n,
        input logic                typed,
        input result_t             want
    );
        result_t predicted;
        int      gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid         <= 1'b1;
        cmd              <= c;
        address          <= a;
        length           <= l;
        access_mode      <= m;
        component_number <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_decode(c, a, l, m, n);
        decode_answers_q.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Reset, directed table, random traffic, drain and verdict
    initial
    begin
        logic [CMD_W-1:0]    c;
        logic [ADDR_W-1:0]   a;
        logic [LENGTH_W-1:0] l;
        logic [ADDR_W-1:0]   off;
        logic [ADDR_W-1:0]   base;
        logic [LENGTH_W-1:0] sz;
        int                  pick;
        int                  idx;
        int                  i;
        for (i = 0; i < RANGE_ENTRIES; i++)
            tbl_valid[i] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
            offer_item(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].len,
                       directed_rows[i].mode, directed_rows[i].comp,
                       directed_rows[i].typed, directed_rows[i].want);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Drop valid and let every answer come back once
            if (items_sent == DRAIN_AT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (decode_answers_q.size() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(99);
            idx  = (tbl_used > 0) ? $urandom_range(tbl_used - 1) : 0;
            base = tbl_base[idx];
            sz   = tbl_size[idx];
            if (tbl_used == 0 && pick >= 15 && pick < 90)
                pick = 90;
            if (pick < 15)
            begin
                // New range: free, adjacent, just below or inside a stored one
                c = CMD_REGISTER;
                case ((tbl_used > 0) ? $urandom_range(3) : 0)
                    0: a = {$urandom, $urandom};
                    1: a = base + {32'b0, sz} + $urandom_range(0, 3);
                    2: a = base - $urandom_range(1, 300);
                    default: a = base + ({32'b0, $urandom} % ({32'b0, sz} + 64'd1));
                endcase
                case ($urandom_range(9))
                    0: l = '0;
                    1: l = LEN_MAX;
                    2, 3, 4: l = $urandom;
                    default: l = $urandom_range(1, 256);
                endcase
            end
            else if (pick < 90)
            begin
                // Lookup aimed at the edges and the inside of a stored range
                c = $urandom_range(1) ? CMD_WRITE : CMD_READ;
                case ($urandom_range(3))
                    0: l = '0;
                    1: l = $urandom_range(1, 16);
                    2: l = $urandom;
                    default: l = sz;
                endcase
                case ($urandom_range(4))
                    0: off = '0;
                    1: off = {32'b0, sz} - {32'b0, l};
                    2: off = {32'b0, $urandom} % ({32'b0, sz} + 64'd1);
                    3: off = {32'b0, sz} - {32'b0, l} + 64'd1;
                    default: off = '1;
                endcase
                a = base + off;
            end
            else if (pick < 97)
            begin
                c = $urandom_range(1) ? CMD_WRITE : CMD_READ;
                a = {$urandom, $urandom};
                l = $urandom;
            end
            else
            begin
                c = CMD_UNUSED;
                a = {$urandom, $urandom};
                l = $urandom;
            end
            offer_item(c, a, l, MODE_W'($urandom_range(3)), COMP_W'($urandom_range(15)),
                       1'b0, NO_ANSWER);
        end

        in_valid <= 1'b0;
        while (decode_answers_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && decode_answers_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Stall the receiver in phases of varying style, with one long hold-off
    initial
    begin
        int style;
        int phase_len;
        int k;
        wait (rst_n);
        forever
        begin
            if (!holdoff_done && items_sent >= HOLDOFF_AT)
            begin
                out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                holdoff_done = 1'b1;
            end
            style     = $urandom_range(3);
            phase_len = $urandom_range(20, 80);
            for (k = 0; k < phase_len; k++)
            begin
                case (style)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(1));
                    2: out_ready <= (k % 4 != 3);
                    default: out_ready <= ($urandom_range(9) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Compare each answer transfer with the oldest prediction
    always @(posedge clk)
    begin : check_answers
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decode_answers_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected answer: status %0d comp %0d offset %h",
                             status, target_component, range_offset);
            end
            else
            begin
                want = decode_answers_q.pop_front();
                if (status != want.status || target_component != want.target ||
                    range_offset != want.offset)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("answer mismatch: status %0d/%0d comp %0d/%0d offset %h/%h",
                                 want.status, status, want.target, target_component,
                                 want.offset, range_offset);
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
